>>> sv/sdlr_pkg.sv
// Shared types and constants for the servo duty linear ramp block.
// No dependencies; used by sdlr_ctrl, sdlr_dpath and servo_duty_linear_ramp.
package sdlr_pkg;

    localparam int LEN_W  = 16;   // ramp length / elapsed count width
    localparam int DUTY_W = 10;   // duty compare value width
    localparam int PROD_W = LEN_W + DUTY_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;

    // one quotient bit per divider step; quotient never exceeds the duty range
    localparam int DIV_STEPS = DUTY_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY   = 2'd2;

    // reset values
    localparam logic [LEN_W-1:0]  RST_RAMP_LENGTH = 16'd600;
    localparam logic [DUTY_W-1:0] RST_LOW_DUTY    = 10'd49;
    localparam logic [DUTY_W-1:0] RST_HIGH_DUTY   = 10'd98;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture tick, update ramp state
        logic mul_a;     // start * (len - p)
        logic mul_b;     // add target * p, seed divider
        logic div_step;  // one restoring division step
        logic fin;       // write present duty and output register
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

>>> sv/sdlr_ctrl.sv
// Controller state machine for the servo duty linear ramp block.
// Depends on sdlr_pkg; drives sdlr_dpath through t_cmd / t_status.
module sdlr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sdlr_pkg::t_status i_status,
    output sdlr_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL_A = 5'b00010,
        S_MUL_B = 5'b00100,
        S_DIV   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [sdlr_pkg::STEP_W-1:0] r_step, n_step;
    logic step_last;

    assign step_last  = (r_step == sdlr_pkg::STEP_W'(sdlr_pkg::DIV_STEPS - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_step      = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (step_last) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MUL_A))
        else $error("accepted tick did not start the multiply");
    a_fin_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_status.out_free)
        else $error("result written while output register busy");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |->
            (r_step <= sdlr_pkg::STEP_W'(sdlr_pkg::DIV_STEPS - 1)))
        else $error("divider step count overran");
`endif

endmodule

>>> sv/sdlr_dpath.sv
// Datapath for the servo duty linear ramp block: config registers, ramp
// state, multiply, restoring divider and output register.
// Depends on sdlr_pkg; commanded by sdlr_ctrl.
module sdlr_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdlr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sdlr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_crossing_active,
    input  sdlr_pkg::t_cmd                    i_cmd,
    output sdlr_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sdlr_pkg::DUTY_W-1:0]       o_duty_out,
    output logic                              o_ramp_done
);

    logic [sdlr_pkg::LEN_W-1:0]  r_len;
    logic [sdlr_pkg::DUTY_W-1:0] r_low, r_high;
    logic [sdlr_pkg::DUTY_W-1:0] r_present, r_start, r_target;
    logic [sdlr_pkg::LEN_W-1:0]  r_elapsed;
    logic                        r_rising, r_falling;
    logic [sdlr_pkg::PROD_W-1:0] r_prod;
    logic [sdlr_pkg::LEN_W-1:0]  r_rem;
    logic [sdlr_pkg::DUTY_W-1:0] r_quo;
    logic                        r_out_valid;
    logic [sdlr_pkg::DUTY_W-1:0] r_out_duty;
    logic                        r_out_done;

    logic                        start_rise, start_fall;
    logic [sdlr_pkg::LEN_W-1:0]  elapsed_base, n_elapsed;
    logic [sdlr_pkg::LEN_W-1:0]  p, rest;
    logic [sdlr_pkg::NUM_W-1:0]  num;
    logic [sdlr_pkg::LEN_W:0]    trial, diff;
    logic                        ge;
    logic [sdlr_pkg::DUTY_W-1:0] duty;

    // ramp restart on flag edge (also first tick after reset)
    assign start_rise   = i_crossing_active && !r_rising;
    assign start_fall   = !i_crossing_active && !r_falling;
    assign elapsed_base = (start_rise || start_fall) ? '0 : r_elapsed;
    assign n_elapsed    = (elapsed_base < r_len) ? elapsed_base + 1'b1 : elapsed_base;

    // p = min(elapsed, len)
    assign p    = (r_elapsed < r_len) ? r_elapsed : r_len;
    assign rest = r_len - p;
    assign num  = sdlr_pkg::NUM_W'(r_prod)
                + sdlr_pkg::NUM_W'(sdlr_pkg::PROD_W'(r_target) * sdlr_pkg::PROD_W'(p));

    // restoring step: dividend low bits shift out of r_quo, quotient bits in
    assign trial = {r_rem, r_quo[sdlr_pkg::DUTY_W-1]};
    assign diff  = trial - {1'b0, r_len};
    assign ge    = (trial >= {1'b0, r_len});

    // zero length: ramp counts as complete, no division
    assign duty = (r_len == '0) ? r_target : r_quo;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_duty_out  = r_out_duty;
    assign o_ramp_done = r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= sdlr_pkg::RST_RAMP_LENGTH;
            r_low       <= sdlr_pkg::RST_LOW_DUTY;
            r_high      <= sdlr_pkg::RST_HIGH_DUTY;
            r_present   <= sdlr_pkg::RST_LOW_DUTY;
            r_start     <= sdlr_pkg::RST_LOW_DUTY;
            r_target    <= sdlr_pkg::RST_LOW_DUTY;
            r_elapsed   <= '0;
            r_rising    <= 1'b0;
            r_falling   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sdlr_pkg::CFG_RAMP_LENGTH: r_len  <= i_cfg_data;
                    sdlr_pkg::CFG_LOW_DUTY:    r_low  <= i_cfg_data[sdlr_pkg::DUTY_W-1:0];
                    sdlr_pkg::CFG_HIGH_DUTY:   r_high <= i_cfg_data[sdlr_pkg::DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_elapsed <= n_elapsed;
                if (start_rise) begin
                    r_start   <= r_present;
                    r_target  <= r_high;
                    r_rising  <= 1'b1;
                    r_falling <= 1'b0;
                end else if (start_fall) begin
                    r_start   <= r_present;
                    r_target  <= r_low;
                    r_falling <= 1'b1;
                    r_rising  <= 1'b0;
                end
            end
            if (i_cmd.fin) begin
                r_present   <= duty;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            r_prod <= sdlr_pkg::PROD_W'(r_start) * sdlr_pkg::PROD_W'(rest);
        end
        if (i_cmd.mul_b) begin
            // top bits are below len, so they fit the remainder
            r_rem <= num[sdlr_pkg::LEN_W+sdlr_pkg::DUTY_W-1:sdlr_pkg::DUTY_W];
            r_quo <= num[sdlr_pkg::DUTY_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[sdlr_pkg::LEN_W-1:0] : trial[sdlr_pkg::LEN_W-1:0];
            r_quo <= {r_quo[sdlr_pkg::DUTY_W-2:0], ge};
        end
        if (i_cmd.fin) begin
            r_out_duty <= duty;
            r_out_done <= (r_elapsed >= r_len);
        end
    end

`ifndef SYNTHESIS
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && (r_len != '0)) |-> (r_rem < r_len))
        else $error("divider remainder not below ramp length");
    a_duty_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && (r_len != '0)) |->
            ((r_quo >= r_start || r_quo >= r_target) &&
             (r_quo <= r_start || r_quo <= r_target)))
        else $error("ramp duty outside start/target span");
`endif

endmodule

>>> sv/servo_duty_linear_ramp.sv
// Per tick: capture, multiply (start term, then target term), the 10-step
// restoring divider and the output write; one item in flight at a time.
// A new tick is taken while the previous result waits in the output register;
// the result write itself waits until the output register is free.
// Reset (i_rst_n, synchronous, active low) restores the config registers to
// 600/49/98, duty state to 49, clears elapsed count, flags and valid.
module servo_duty_linear_ramp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sdlr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sdlr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // tick input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_crossing_active,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [sdlr_pkg::DUTY_W-1:0]     o_duty_out,
    output logic                            o_ramp_done
);

    // command / status between controller and datapath
    sdlr_pkg::t_cmd    cmd;
    sdlr_pkg::t_status status;

    // sequencer: idle -> multiply (2) -> divide (10) -> write result
    sdlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // ramp state, interpolation arithmetic and output register; the output
    // register decouples the result transfer from the next input transfer
    sdlr_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_crossing_active (i_crossing_active),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_duty_out        (o_duty_out),
        .o_ramp_done       (o_ramp_done)
    );

endmodule

>>> verif/servo_duty_linear_ramp_tb.sv
// Self-checking testbench for servo_duty_linear_ramp: tick transfers in, duty results out,
// each result checked against an untimed prediction of the ramp.
// Depends on sdlr_pkg and the servo_duty_linear_ramp RTL.
module servo_duty_linear_ramp_tb;

    // index 3 maps to no register; writes there must change nothing
    localparam logic [sdlr_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int unsigned DRAIN_PAUSE  = 32;
    localparam int unsigned LIMIT_CYCLES = 400_000;  // several times the slowest run
    localparam int unsigned PRINT_CAP    = 40;       // keep a broken run's log short

    typedef struct packed {
        logic [sdlr_pkg::DUTY_W-1:0] duty;
        logic                        done;
    } t_duty_result;

    // DUT ports
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sdlr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [sdlr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_crossing_active;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [sdlr_pkg::DUTY_W-1:0]     o_duty_out;
    logic                            o_ramp_done;

    // register mirror, starts at the reset values
    logic [sdlr_pkg::LEN_W-1:0]  mirror_len  = sdlr_pkg::RST_RAMP_LENGTH;
    logic [sdlr_pkg::DUTY_W-1:0] mirror_low  = sdlr_pkg::RST_LOW_DUTY;
    logic [sdlr_pkg::DUTY_W-1:0] mirror_high = sdlr_pkg::RST_HIGH_DUTY;

    // predicted ramp state
    logic [sdlr_pkg::DUTY_W-1:0] duty_now   = sdlr_pkg::RST_LOW_DUTY;  // last duty driven
    logic [sdlr_pkg::DUTY_W-1:0] seg_from   = sdlr_pkg::RST_LOW_DUTY;  // ramp start point
    logic [sdlr_pkg::DUTY_W-1:0] seg_to     = sdlr_pkg::RST_LOW_DUTY;  // ramp end point
    logic [sdlr_pkg::LEN_W-1:0]  seg_ticks  = '0;  // ticks into the current ramp
    logic                        rise_armed = 1'b0;
    logic                        fall_armed = 1'b0;

    t_duty_result duty_pending[$];   // predicted results, oldest first
    int unsigned  mismatch_count = 0;
    int unsigned  sink_hold      = 0;     // long receiver hold-off request, in cycles
    logic         steady         = 1'b0;  // no idling on either side while set

    servo_duty_linear_ramp uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_crossing_active (i_crossing_active),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_duty_out        (o_duty_out),
        .o_ramp_done       (o_ramp_done)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int unsigned draw_gap();
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One tick of the ramp. Edge of the flag (or first tick after reset)
    // restarts the ramp from the present duty; then the count saturates
    // at the live ramp length and the duty is interpolated.
    function automatic t_duty_result advance_ramp(input logic act);
        int unsigned  span;
        int unsigned  from;
        int unsigned  to;
        int unsigned  ticks;
        int unsigned  p;
        int unsigned  num;
        t_duty_result r;
        if (act && !rise_armed) begin
            seg_from   = duty_now;
            seg_to     = mirror_high;
            seg_ticks  = '0;
            rise_armed = 1'b1;
            fall_armed = 1'b0;
        end else if (!act && !fall_armed) begin
            seg_from   = duty_now;
            seg_to     = mirror_low;
            seg_ticks  = '0;
            fall_armed = 1'b1;
            rise_armed = 1'b0;
        end
        span = 32'(mirror_len);
        if (32'(seg_ticks) < span) seg_ticks = seg_ticks + 1'b1;
        ticks = 32'(seg_ticks);
        if (span == 0) begin
            // zero length: ramp counts as finished, no division
            r.duty = seg_to;
            r.done = 1'b1;
        end else begin
            from   = 32'(seg_from);
            to     = 32'(seg_to);
            p      = (ticks < span) ? ticks : span;
            num    = from * (span - p) + to * p;
            r.duty = sdlr_pkg::DUTY_W'(num / span);
            r.done = (ticks >= span);
        end
        duty_now = r.duty;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    endtask

    // Register write; the enable drops with the next tick or drain.
    task automatic write_reg(input logic [sdlr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sdlr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            sdlr_pkg::CFG_RAMP_LENGTH: mirror_len  = data;
            sdlr_pkg::CFG_LOW_DUTY:    mirror_low  = data[sdlr_pkg::DUTY_W-1:0];
            sdlr_pkg::CFG_HIGH_DUTY:   mirror_high = data[sdlr_pkg::DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one tick and wait for its transfer. Valid stays high afterwards
    // so back-to-back ticks go out without a bubble.
    task automatic push_tick(input logic act);
        int unsigned gap;
        gap = draw_gap();
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_crossing_active <= act;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        duty_pending.push_back(advance_ramp(act));
    endtask

    // Stop offering and wait until every predicted result has arrived.
    task automatic settle_ramp();
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b0;
        do @(posedge i_clk); while (duty_pending.size() != 0);
    endtask

    function automatic logic [sdlr_pkg::CFG_DATA_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll < 4)  return sdlr_pkg::CFG_DATA_W'($urandom_range(13, 300));
        return sdlr_pkg::CFG_DATA_W'($urandom_range(1, 12));
    endfunction

    // Duty words carry random junk above bit 9; the block must drop it.
    function automatic logic [sdlr_pkg::CFG_DATA_W-1:0] pick_duty();
        logic [sdlr_pkg::CFG_DATA_W-1:0] word;
        int unsigned                     roll;
        word = sdlr_pkg::CFG_DATA_W'($urandom);
        roll = $urandom_range(0, 9);
        if (roll == 0)
            word[sdlr_pkg::DUTY_W-1:0] = '0;
        else if (roll == 1)
            word[sdlr_pkg::DUTY_W-1:0] = '1;
        else
            word[sdlr_pkg::DUTY_W-1:0] = sdlr_pkg::DUTY_W'($urandom_range(0, 1023));
        return word;
    endfunction

    // ---------------- tests ----------------

    // First tick after reset starts a ramp even with the flag low;
    // default 600-tick ramp toward the default duties.
    task automatic test_after_reset();
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
    endtask

    // Shortest ramp, duty registers at 0 and at 1023 (above the servo range).
    task automatic test_duty_extremes();
        settle_ramp();
        write_reg(sdlr_pkg::CFG_RAMP_LENGTH, 16'd1);
        write_reg(sdlr_pkg::CFG_LOW_DUTY, 16'h0000);
        write_reg(sdlr_pkg::CFG_HIGH_DUTY, 16'hFFFF);
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b1);
        settle_ramp();
        write_reg(sdlr_pkg::CFG_RAMP_LENGTH, 16'd3);
        write_reg(sdlr_pkg::CFG_LOW_DUTY, 16'h03FF);
        write_reg(sdlr_pkg::CFG_HIGH_DUTY, 16'hFC00);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b0);
    endtask

    // Zero length: duty jumps to the target, done at once.
    task automatic test_zero_length();
        settle_ramp();
        write_reg(sdlr_pkg::CFG_RAMP_LENGTH, 16'd0);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b0);
    endtask

    // Longest length, then shortened mid-ramp so the count is clamped;
    // then a write to the unmapped index.
    task automatic test_length_change();
        settle_ramp();
        write_reg(sdlr_pkg::CFG_RAMP_LENGTH, 16'hFFFF);
        push_tick(1'b1);
        push_tick(1'b1);
        push_tick(1'b1);
        settle_ramp();
        write_reg(sdlr_pkg::CFG_RAMP_LENGTH, 16'd2);
        push_tick(1'b1);
        settle_ramp();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b0);
    endtask

    // Random phases: new settings, then mostly full ramps (flag held long
    // enough to finish) mixed with short flips and noise.
    task automatic test_random_ramps();
        logic        flag;
        int unsigned run;
        int unsigned sent;
        flag = 1'b0;
        for (int phase = 0; phase < 12; phase++) begin
            settle_ramp();
            steady = (phase % 4 == 3);
            if ($urandom_range(0, 3) != 0)
                write_reg(sdlr_pkg::CFG_RAMP_LENGTH, pick_length());
            if ($urandom_range(0, 2) != 0) write_reg(sdlr_pkg::CFG_LOW_DUTY, pick_duty());
            if ($urandom_range(0, 2) != 0) write_reg(sdlr_pkg::CFG_HIGH_DUTY, pick_duty());
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_UNMAPPED, sdlr_pkg::CFG_DATA_W'($urandom));
            sent = 0;
            while (sent < 40) begin
                if ($urandom_range(0, 9) < 7) begin
                    flag = ~flag;
                    run  = 32'(mirror_len) + $urandom_range(0, 3);
                    if (run > 24) run = 24;
                end else begin
                    flag = 1'($urandom_range(0, 1));
                    run  = $urandom_range(1, 2);
                end
                repeat (run) begin
                    push_tick(flag);
                    sent++;
                end
            end
            steady = 1'b0;
        end
    endtask

    // Receiver holds off for a long stretch while ticks keep coming, so the
    // output register fills and the input side stalls.
    task automatic test_output_backpressure();
        settle_ramp();
        write_reg(sdlr_pkg::CFG_RAMP_LENGTH, 16'd5);
        sink_hold = 300;
        steady    = 1'b1;
        for (int k = 0; k < 16; k++) push_tick(k[2]);
        steady = 1'b0;
        settle_ramp();
    endtask

    // ---------------- processes ----------------

    initial begin : stimulus
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= sdlr_pkg::CFG_RAMP_LENGTH;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_crossing_active <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_duty_extremes();
        test_zero_length();
        test_length_change();
        test_random_ramps();
        test_output_backpressure();

        settle_ramp();
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        if (mismatch_count == 0 && duty_pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side ready: random stalls, plus the long hold-off on request.
    initial begin : result_sink
        int unsigned stall;
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (sink_hold != 0) begin
                i_out_ready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end
            stall = draw_gap();
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Each result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_duty_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (duty_pending.size() == 0) begin
                flag_mismatch("unexpected result", 16'(o_duty_out), 16'h0);
            end else begin
                want = duty_pending.pop_front();
                if (o_duty_out !== want.duty)
                    flag_mismatch("duty_out", 16'(o_duty_out), 16'(want.duty));
                if (o_ramp_done !== want.done)
                    flag_mismatch("ramp_done", 16'(o_ramp_done), 16'(want.done));
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 4);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
